// ===== rtl/core/gsm_pkg.sv =====
package gsm_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);

   localparam int PIX_W  = 16;
   localparam int WGT_W  = 16;
   localparam int IW_W   = 11;
   localparam int CMP_W  = (ADDR_W + 1 > IW_W) ? ADDR_W + 1 : IW_W;

   // four taps summed, times a weight, three products summed
   localparam int SUM_W   = PIX_W + 2;
   localparam int PROD_W  = SUM_W + WGT_W;
   localparam int CPROD_W = PIX_W + WGT_W;
   localparam int ACC_W   = PROD_W + 2;

   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (WGT_W - 1);
   localparam logic [PIX_W-1:0] PIX_MAX    = '1;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [IW_W-1:0]  RST_IMAGE_WIDTH = IW_W'(1024);
   localparam logic [WGT_W-1:0] RST_CORNER      = WGT_W'(4923);
   localparam logic [WGT_W-1:0] RST_EDGE        = WGT_W'(8116);
   localparam logic [WGT_W-1:0] RST_CENTER      = WGT_W'(13381);

   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH,
      REG_CORNER_WEIGHT,
      REG_EDGE_WEIGHT,
      REG_CENTER_WEIGHT
   } gsm_reg_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_in;
      logic             drain;
   } gsm_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             end_of_row;
      logic             end_of_frame;
      logic             last_of_run;
   } gsm_rsp_type;

   // one line store entry: rows r-2 and r-1 at one column
   typedef struct packed {
      logic [PIX_W-1:0] upper;
      logic [PIX_W-1:0] middle;
   } gsm_line_type;

   typedef struct packed {
      logic [PIX_W-1:0]  pixel;
      logic              drain;
      logic [ADDR_W-1:0] col;
      logic              last;
      logic              first;
   } gsm_item_type;

   typedef struct packed {
      logic [WGT_W-1:0] corner;
      logic [WGT_W-1:0] edge_w;
      logic [WGT_W-1:0] center;
   } gsm_weights_type;

   typedef struct packed {
      logic [SUM_W-1:0] a_cor;
      logic [SUM_W-1:0] a_edg;
      logic [PIX_W-1:0] a_cen;
      logic [SUM_W-1:0] b_cor;
      logic [SUM_W-1:0] b_edg;
      logic [PIX_W-1:0] b_cen;
      logic             a_v;
      logic             b_v;
      logic             eof;
   } gsm_sums_type;

   typedef struct packed {
      logic [PIX_W-1:0] a_pix;
      logic [PIX_W-1:0] b_pix;
      logic             a_v;
      logic             b_v;
      logic             eof;
   } gsm_pair_type;

endpackage

// ===== rtl/core/gaussian_smooth_3x3_clamped.sv =====
// channel  ports                      beat
// -------  -------------------------  ---------------------------------------------
// req      req_valid/ready/data       one raster pixel or drain marker
// rsp      rsp_valid/ready/data       one smoothed pixel with row/frame/run flags
// csr      csr_psel..csr_pready       APB write/read of width and three weights
//
// One req beat per cycle unless rsp stalls or a two-result beat waits. The first
// result of a beat passes through line store read, tap sums, weight products and
// the output register. A beat with two results (last column) holds req_ready low
// while both wait. Synchronous reset clears control state; the line stores are not
// cleared. A stalled rsp freezes the whole pipeline, line store read port included.
module gaussian_smooth_3x3_clamped (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  gsm_pkg::gsm_req_type       req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output gsm_pkg::gsm_rsp_type       rsp_data,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [gsm_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [gsm_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [gsm_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic [gsm_pkg::IW_W-1:0]  image_width_ff;
   gsm_pkg::gsm_weights_type  weights_ff;
   gsm_pkg::gsm_reg_type      reg_sel;
   logic                      csr_wr;

   logic [gsm_pkg::ADDR_W-1:0] col_cnt_ff, col_cnt_in;
   logic                       first_ff, first_in;
   logic [gsm_pkg::CMP_W-1:0]  w_ext, w_eff, c_inc;
   logic                       last;
   logic                       accept, take;
   logic                       adv;

   gsm_pkg::gsm_item_type item_ff;
   logic                  item_v_ff;
   gsm_pkg::gsm_line_type line_rd, line_wd;
   logic                  line_we;
   gsm_pkg::gsm_sums_type sums;
   gsm_pkg::gsm_pair_type pair;

   gsm_pkg::gsm_rsp_type slot_a_ff, slot_b_ff;
   logic                 slot_a_v_ff, slot_b_v_ff;
   logic                 rsp_take;

   // ---- configuration ----
   assign csr_pready = 1'b1;
   assign reg_sel    = gsm_pkg::gsm_reg_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= gsm_pkg::RST_IMAGE_WIDTH;
         weights_ff.corner <= gsm_pkg::RST_CORNER;
         weights_ff.edge_w <= gsm_pkg::RST_EDGE;
         weights_ff.center <= gsm_pkg::RST_CENTER;
      end else if (csr_wr) begin
         unique case (reg_sel)
            gsm_pkg::REG_IMAGE_WIDTH:   image_width_ff <= csr_pwdata[gsm_pkg::IW_W-1:0];
            gsm_pkg::REG_CORNER_WEIGHT: weights_ff.corner <= csr_pwdata[gsm_pkg::WGT_W-1:0];
            gsm_pkg::REG_EDGE_WEIGHT:   weights_ff.edge_w <= csr_pwdata[gsm_pkg::WGT_W-1:0];
            gsm_pkg::REG_CENTER_WEIGHT: weights_ff.center <= csr_pwdata[gsm_pkg::WGT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         gsm_pkg::REG_IMAGE_WIDTH:   csr_prdata = gsm_pkg::CSR_DW'(image_width_ff);
         gsm_pkg::REG_CORNER_WEIGHT: csr_prdata = gsm_pkg::CSR_DW'(weights_ff.corner);
         gsm_pkg::REG_EDGE_WEIGHT:   csr_prdata = gsm_pkg::CSR_DW'(weights_ff.edge_w);
         gsm_pkg::REG_CENTER_WEIGHT: csr_prdata = gsm_pkg::CSR_DW'(weights_ff.center);
      endcase
   end

   // ---- pipeline advance: output register can take a new pair ----
   assign rsp_valid = slot_a_v_ff || slot_b_v_ff;
   assign rsp_data  = slot_a_v_ff ? slot_a_ff : slot_b_ff;
   assign rsp_take  = rsp_valid && rsp_ready;
   assign adv       = !rsp_valid || (rsp_ready && (slot_a_v_ff != slot_b_v_ff));
   assign req_ready = adv;
   assign accept    = req_valid && req_ready;

   // ---- column tracking ----
   always_comb begin
      w_ext = gsm_pkg::CMP_W'(image_width_ff);
      if (w_ext == '0) begin
         w_eff = gsm_pkg::CMP_W'(1);
      end else if (w_ext > gsm_pkg::CMP_W'(gsm_pkg::MAX_WIDTH)) begin
         w_eff = gsm_pkg::CMP_W'(gsm_pkg::MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      c_inc = gsm_pkg::CMP_W'(col_cnt_ff) + gsm_pkg::CMP_W'(1);
      last  = (c_inc >= w_eff);

      // drain with no image row pending is swallowed
      take       = accept && !(first_ff && req_data.drain);
      col_cnt_in = col_cnt_ff;
      first_in   = first_ff;
      if (take) begin
         col_cnt_in = last ? '0 : c_inc[gsm_pkg::ADDR_W-1:0];
         if (last && first_ff) begin
            first_in = 1'b0;
         end else if (last && req_data.drain) begin
            first_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         first_ff   <= 1'b1;
      end else begin
         col_cnt_ff <= col_cnt_in;
         first_ff   <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_v_ff <= 1'b0;
      end else if (adv) begin
         item_v_ff <= take;
      end
      if (adv) begin
         item_ff.pixel <= req_data.pixel_in;
         item_ff.drain <= req_data.drain;
         item_ff.col   <= col_cnt_ff;
         item_ff.last  <= last;
         item_ff.first <= first_ff;
      end
   end

   // ---- line stores ----
   assign line_we       = adv && item_v_ff && !item_ff.drain;
   assign line_wd.upper = item_ff.first ? item_ff.pixel : line_rd.middle;
   assign line_wd.middle = item_ff.pixel;

   gsm_line_store u_line (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (adv),
      .rd_addr (col_cnt_ff),
      .wr_en   (line_we),
      .wr_addr (item_ff.col),
      .wr_data (line_wd),
      .rd_data (line_rd)
   );

   gsm_window u_window (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .item_v (item_v_ff),
      .item   (item_ff),
      .line   (line_rd),
      .sums   (sums)
   );

   gsm_weigh u_weigh (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .sums    (sums),
      .weights (weights_ff),
      .pair    (pair)
   );

   // ---- output register: up to two results, A goes first ----
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_a_v_ff <= 1'b0;
         slot_b_v_ff <= 1'b0;
      end else if (adv) begin
         slot_a_v_ff <= pair.a_v;
         slot_b_v_ff <= pair.b_v;
      end else if (rsp_take) begin
         if (slot_a_v_ff) begin
            slot_a_v_ff <= 1'b0;
         end else begin
            slot_b_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         slot_a_ff.pixel_out    <= pair.a_pix;
         slot_a_ff.end_of_row   <= 1'b0;
         slot_a_ff.end_of_frame <= 1'b0;
         slot_a_ff.last_of_run  <= !pair.b_v;
         slot_b_ff.pixel_out    <= pair.b_pix;
         slot_b_ff.end_of_row   <= 1'b1;
         slot_b_ff.end_of_frame <= pair.eof;
         slot_b_ff.last_of_run  <= 1'b1;
      end
   end

endmodule

// ===== rtl/core/gsm_line_store.sv =====
module gsm_line_store (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [gsm_pkg::ADDR_W-1:0] rd_addr,
   input  logic                      wr_en,
   input  logic [gsm_pkg::ADDR_W-1:0] wr_addr,
   input  gsm_pkg::gsm_line_type     wr_data,
   output gsm_pkg::gsm_line_type     rd_data
);

   gsm_pkg::gsm_line_type mem [gsm_pkg::MAX_WIDTH];
   gsm_pkg::gsm_line_type rd_ff;
   gsm_pkg::gsm_line_type fwd_data_ff;
   logic                  fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // same-cycle write and read of one entry (single-column rows)
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
      if (rd_en) begin
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_ff;

endmodule

// ===== rtl/core/gsm_window.sv =====
module gsm_window (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  item_v,
   input  gsm_pkg::gsm_item_type item,
   input  gsm_pkg::gsm_line_type line,
   output gsm_pkg::gsm_sums_type sums
);

   logic [gsm_pkg::PIX_W-1:0] win_ff [6];
   logic [gsm_pkg::PIX_W-1:0] cur [3];
   logic [gsm_pkg::PIX_W-1:0] lft [3];
   logic [gsm_pkg::PIX_W-1:0] mid [3];
   logic                      col_zero;
   gsm_pkg::gsm_sums_type     sums_in;
   gsm_pkg::gsm_sums_type     sums_ff;

   function automatic logic [gsm_pkg::SUM_W-1:0] add4(
      input logic [gsm_pkg::PIX_W-1:0] a,
      input logic [gsm_pkg::PIX_W-1:0] b,
      input logic [gsm_pkg::PIX_W-1:0] c,
      input logic [gsm_pkg::PIX_W-1:0] d
   );
      add4 = gsm_pkg::SUM_W'(a) + gsm_pkg::SUM_W'(b)
           + gsm_pkg::SUM_W'(c) + gsm_pkg::SUM_W'(d);
   endfunction

   always_comb begin
      cur[0]   = line.upper;
      cur[1]   = line.middle;
      cur[2]   = item.drain ? line.middle : item.pixel;
      col_zero = (item.col == '0);
      for (int i = 0; i < 3; i++) begin
         lft[i] = col_zero ? cur[i] : win_ff[i];
         mid[i] = col_zero ? cur[i] : win_ff[i+3];
      end

      // A: column c-1 between left and current; B: column c, right replicated
      sums_in.a_cor = add4(lft[0], lft[2], cur[0], cur[2]);
      sums_in.a_edg = add4(mid[0], mid[2], lft[1], cur[1]);
      sums_in.a_cen = mid[1];
      sums_in.b_cor = add4(mid[0], mid[2], cur[0], cur[2]);
      sums_in.b_edg = add4(cur[0], cur[2], mid[1], cur[1]);
      sums_in.b_cen = cur[1];
      sums_in.a_v   = item_v && !item.first && !col_zero;
      sums_in.b_v   = item_v && !item.first && item.last;
      sums_in.eof   = item.drain;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (adv && item_v && !item.first) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i]   <= mid[i];
            win_ff[i+3] <= cur[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff.a_v <= 1'b0;
         sums_ff.b_v <= 1'b0;
      end else if (adv) begin
         sums_ff <= sums_in;
      end
   end

   assign sums = sums_ff;

endmodule

// ===== rtl/core/gsm_weigh.sv =====
module gsm_weigh (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  gsm_pkg::gsm_sums_type    sums,
   input  gsm_pkg::gsm_weights_type weights,
   output gsm_pkg::gsm_pair_type    pair
);

   logic [gsm_pkg::PROD_W-1:0]  a_cor_ff, a_edg_ff, b_cor_ff, b_edg_ff;
   logic [gsm_pkg::CPROD_W-1:0] a_cen_ff, b_cen_ff;
   logic                        a_v_ff, b_v_ff, eof_ff;

   function automatic logic [gsm_pkg::PIX_W-1:0] round_sat(
      input logic [gsm_pkg::PROD_W-1:0]  cor,
      input logic [gsm_pkg::PROD_W-1:0]  edg,
      input logic [gsm_pkg::CPROD_W-1:0] cen
   );
      logic [gsm_pkg::ACC_W-1:0] acc;
      logic [gsm_pkg::ACC_W-1:0] q;
      acc = gsm_pkg::ACC_W'(cor) + gsm_pkg::ACC_W'(edg) + gsm_pkg::ACC_W'(cen)
          + gsm_pkg::ROUND_HALF;
      q   = acc >> gsm_pkg::WGT_W;
      if (q[gsm_pkg::ACC_W-1:gsm_pkg::PIX_W] != '0) begin
         round_sat = gsm_pkg::PIX_MAX;
      end else begin
         round_sat = q[gsm_pkg::PIX_W-1:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         a_cor_ff <= sums.a_cor * weights.corner;
         a_edg_ff <= sums.a_edg * weights.edge_w;
         a_cen_ff <= sums.a_cen * weights.center;
         b_cor_ff <= sums.b_cor * weights.corner;
         b_edg_ff <= sums.b_edg * weights.edge_w;
         b_cen_ff <= sums.b_cen * weights.center;
         eof_ff   <= sums.eof;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= sums.a_v;
         b_v_ff <= sums.b_v;
      end
   end

   always_comb begin
      pair.a_pix = round_sat(a_cor_ff, a_edg_ff, a_cen_ff);
      pair.b_pix = round_sat(b_cor_ff, b_edg_ff, b_cen_ff);
      pair.a_v   = a_v_ff;
      pair.b_v   = b_v_ff;
      pair.eof   = eof_ff;
   end

endmodule

// ===== rtl/core/gsm_checker.sv =====
module gsm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input gsm_pkg::gsm_rsp_type rsp_data,
   input logic                 csr_pready
);

   // a waiting result holds its beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // frame end only on a row end that closes its run
   a_eof_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.end_of_frame |-> rsp_data.end_of_row && rsp_data.last_of_run)
      else $error("end_of_frame without end_of_row and last_of_run");

   // the row end is always the last result of its input beat
   a_eor_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.end_of_row |-> rsp_data.last_of_run)
      else $error("end_of_row without last_of_run");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // nothing waiting on rsp: req beat is taken, csr always ready
   a_pready: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready && csr_pready)
      else $error("req_ready or csr_pready low with rsp empty");

endmodule

bind gaussian_smooth_3x3_clamped gsm_checker u_gsm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);
